// File: hw/rtl/sfpc_pkg.sv
// ----------------------------------------------------------------------------
// Front panel controller package
// Shared types, codes, constants and small lookup functions of the front
// panel controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpc_pkg;

  localparam int KNOB_W      = 12;
  localparam int NUM_KNOBS   = 5;
  localparam int SUM_W       = 16;
  localparam int NUM_BTNS    = 4;
  localparam int SAMPLES_DEF = 10;

  localparam int KNOB_TIME   = 0;
  localparam int KNOB_VOLT   = 1;
  localparam int KNOB_TRIG   = 2;
  localparam int KNOB_FREQ_A = 3;
  localparam int KNOB_FREQ_B = 4;

  localparam int BTN_SCROLL = 0;
  localparam int BTN_SELECT = 1;
  localparam int BTN_LEFT   = 2;
  localparam int BTN_RIGHT  = 3;

  localparam int TRIG_SPAN        = 62 - 1;
  localparam int TIME_STEPS       = 6;
  localparam int FREQ_BASE        = 50;
  localparam int FREQ_SPAN        = 20000 - 50;
  localparam int FREQ_STEP        = 50;
  localparam int FREQ_RECIP_SHIFT = 22;
  localparam int FREQ_RECIP       = (2 ** FREQ_RECIP_SHIFT + FREQ_STEP - 1) / FREQ_STEP;

  localparam logic [4:0] OFFSET_MIN = 5'd1;
  localparam logic [4:0] OFFSET_MAX = 5'd30;

  localparam logic [1:0] WAVE_FIRST  = 2'd0;
  localparam logic [1:0] WAVE_SECOND = 2'd1;
  localparam logic [1:0] WAVE_THIRD  = 2'd2;

  typedef enum logic [2:0] {
    SCR_MENU0 = 3'd0,
    SCR_MENU1 = 3'd1,
    SCR_MENU2 = 3'd2,
    SCR_SCOPE = 3'd3,
    SCR_GEN   = 3'd4,
    SCR_ABOUT = 3'd5
  } screen_t;

  typedef struct packed {
    logic              scroll_level;
    logic              select_level;
    logic              left_level;
    logic              right_level;
    logic [KNOB_W-1:0] knob_time;
    logic [KNOB_W-1:0] knob_volt;
    logic [KNOB_W-1:0] knob_trig;
    logic [KNOB_W-1:0] knob_freq_a;
    logic [KNOB_W-1:0] knob_freq_b;
  } round_t;

  typedef struct packed {
    screen_t           screen;
    logic [1:0]        wave_a;
    logic [1:0]        wave_b;
    logic [4:0]        trace_offset;
    logic [5:0]        trigger_level;
    logic [2:0]        volt_div;
    logic [2:0]        time_div_index;
    logic [6:0]        sample_skip;
    logic [14:0]       freq_a;
    logic [14:0]       freq_b;
    logic [KNOB_W-1:0] amp_a;
    logic [KNOB_W-1:0] amp_b;
  } panel_t;

  typedef struct packed {
    logic [NUM_KNOBS-1:0][KNOB_W-1:0] mean;
    screen_t                          screen;
    logic [1:0]                       wave_a;
    logic [1:0]                       wave_b;
    logic [4:0]                       offset;
  } mean_t;

  typedef struct packed {
    screen_t           screen;
    logic [1:0]        wave_a;
    logic [1:0]        wave_b;
    logic [4:0]        offset;
    logic [5:0]        trig;
    logic [2:0]        volt;
    logic [2:0]        tdiv;
    logic [14:0]       freq_raw_a;
    logic [14:0]       freq_raw_b;
    logic [KNOB_W-1:0] amp_a;
    logic [KNOB_W-1:0] amp_b;
  } scaled_t;

  function automatic logic [1:0] next_wave(input logic [1:0] w);
    logic [1:0] r;
    case (w)
      WAVE_FIRST:  r = WAVE_SECOND;
      WAVE_SECOND: r = WAVE_THIRD;
      default:     r = WAVE_FIRST;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] skip_for_index(input logic [2:0] idx);
    logic [6:0] r;
    case (idx)
      3'd0:    r = 7'd1;
      3'd1:    r = 7'd5;
      3'd2:    r = 7'd10;
      3'd3:    r = 7'd19;
      3'd4:    r = 7'd48;
      default: r = 7'd96;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sfpc_front.sv
// ----------------------------------------------------------------------------
// Front panel input stage
// Registers each sampling round, sums the knob samples over a block of
// rounds, takes the mean on the last round and handles the button edges.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpc_front import sfpc_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire round_t round,
  input  wire logic   round_valid,
  output logic        round_stall,
  output mean_t       stage,
  output logic        stage_valid,
  input  wire logic   stage_free
);

  localparam int CNT_W       = $clog2(SAMPLES + 1);
  localparam int RECIP_SHIFT = SUM_W + CNT_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int RECIP       = (2 ** RECIP_SHIFT + SAMPLES - 1) / SAMPLES;
  localparam logic [RECIP_W-1:0] RECIP_L = RECIP_W'(RECIP);

  round_t                           held;
  logic                             held_valid;
  logic                             take;
  logic                             last;
  logic [CNT_W-1:0]                 round_count;
  logic [NUM_KNOBS-1:0][SUM_W-1:0]  sums;
  logic [NUM_KNOBS-1:0][SUM_W-1:0]  total;
  logic [NUM_KNOBS-1:0][KNOB_W-1:0] knobs;
  logic [NUM_KNOBS-1:0][PROD_W-1:0] prod;
  logic [NUM_BTNS-1:0]              prev_levels;
  logic [NUM_BTNS-1:0]              levels;
  logic [NUM_BTNS-1:0]              fall;
  screen_t                          screen_reg;
  screen_t                          screen_scroll;
  screen_t                          screen_next;
  logic [1:0]                       wave_a_reg;
  logic [1:0]                       wave_a_next;
  logic [1:0]                       wave_b_reg;
  logic [1:0]                       wave_b_next;
  logic [4:0]                       offset_reg;
  logic [4:0]                       offset_next;
  mean_t                            stage_next;

  assign round_stall = held_valid && !stage_free;
  assign take        = held_valid && stage_free;
  assign last        = round_count == CNT_W'(SAMPLES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!round_stall) begin
      held_valid <= round_valid;
    end
    if (!round_stall && round_valid) begin
      held <= round;
    end
  end

  assign knobs[KNOB_TIME]   = held.knob_time;
  assign knobs[KNOB_VOLT]   = held.knob_volt;
  assign knobs[KNOB_TRIG]   = held.knob_trig;
  assign knobs[KNOB_FREQ_A] = held.knob_freq_a;
  assign knobs[KNOB_FREQ_B] = held.knob_freq_b;

  always_comb begin
    for (int i = 0; i < NUM_KNOBS; i++) begin
      total[i] = sums[i] + SUM_W'(knobs[i]);
      prod[i]  = PROD_W'(total[i]) * PROD_W'(RECIP_L);
    end
  end

  assign levels = {held.right_level, held.left_level, held.select_level, held.scroll_level};
  assign fall   = prev_levels & ~levels;

  always_comb begin
    screen_scroll = screen_reg;
    if (fall[BTN_SCROLL]) begin
      case (screen_reg)
        SCR_MENU0: screen_scroll = SCR_MENU1;
        SCR_MENU1: screen_scroll = SCR_MENU2;
        SCR_MENU2: screen_scroll = SCR_MENU0;
        default:   screen_scroll = screen_reg;
      endcase
    end
    screen_next = screen_scroll;
    if (fall[BTN_SELECT]) begin
      case (screen_scroll)
        SCR_MENU0: screen_next = SCR_SCOPE;
        SCR_MENU1: screen_next = SCR_GEN;
        SCR_MENU2: screen_next = SCR_ABOUT;
        SCR_SCOPE: screen_next = SCR_MENU0;
        SCR_GEN:   screen_next = SCR_MENU1;
        SCR_ABOUT: screen_next = SCR_MENU2;
        default:   screen_next = SCR_MENU0;
      endcase
    end
    wave_a_next = wave_a_reg;
    wave_b_next = wave_b_reg;
    offset_next = offset_reg;
    if (fall[BTN_LEFT]) begin
      if (screen_next == SCR_GEN) begin
        wave_a_next = next_wave(wave_a_reg);
      end else if (screen_next == SCR_SCOPE && offset_next < OFFSET_MAX) begin
        offset_next = offset_next + 5'd1;
      end
    end
    if (fall[BTN_RIGHT]) begin
      if (screen_next == SCR_GEN) begin
        wave_b_next = next_wave(wave_b_reg);
      end else if (screen_next == SCR_SCOPE && offset_next > OFFSET_MIN) begin
        offset_next = offset_next - 5'd1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_KNOBS; i++) begin
      stage_next.mean[i] = prod[i][RECIP_SHIFT +: KNOB_W];
    end
    stage_next.screen = screen_next;
    stage_next.wave_a = wave_a_next;
    stage_next.wave_b = wave_b_next;
    stage_next.offset = offset_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sums        <= '0;
      round_count <= '0;
      prev_levels <= '1;
      screen_reg  <= SCR_MENU0;
      wave_a_reg  <= WAVE_FIRST;
      wave_b_reg  <= WAVE_FIRST;
      offset_reg  <= OFFSET_MIN;
    end else if (take) begin
      if (last) begin
        sums        <= '0;
        round_count <= '0;
        prev_levels <= levels;
        screen_reg  <= screen_next;
        wave_a_reg  <= wave_a_next;
        wave_b_reg  <= wave_b_next;
        offset_reg  <= offset_next;
      end else begin
        sums        <= total;
        round_count <= round_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_free) begin
      stage_valid <= take && last;
    end
    if (take && last) begin
      stage <= stage_next;
    end
  end

`ifndef SYNTHESIS
  a_last_loads_stage: assert property (@(posedge clk) disable iff (rst)
    take && last |=> stage_valid)
    else $error("Last round of a block did not load the mean stage.");

  a_count_in_block: assert property (@(posedge clk) disable iff (rst)
    round_count <= CNT_W'(SAMPLES - 1))
    else $error("Round counter ran past the end of a block.");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/sfpc_scale.sv
// ----------------------------------------------------------------------------
// Front panel scaling stage
// Maps the knob means onto trigger level, voltage division, time division
// index, raw generator frequencies and amplitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpc_scale import sfpc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire mean_t stage,
  input  wire logic  stage_valid,
  output logic       stage_free,
  output scaled_t    scaled,
  output logic       scaled_valid,
  input  wire logic  scaled_free
);

  logic [17:0] trig_prod;
  logic [14:0] time_prod;
  logic [26:0] freq_a_prod;
  logic [26:0] freq_b_prod;
  scaled_t     scaled_next;

  assign stage_free = !stage_valid || scaled_free;

  assign trig_prod   = 18'(stage.mean[KNOB_TRIG]) * 18'(TRIG_SPAN);
  assign time_prod   = 15'(stage.mean[KNOB_TIME]) * 15'(TIME_STEPS);
  assign freq_a_prod = 27'(stage.mean[KNOB_FREQ_A]) * 27'(FREQ_SPAN);
  assign freq_b_prod = 27'(stage.mean[KNOB_FREQ_B]) * 27'(FREQ_SPAN);

  always_comb begin
    scaled_next.screen     = stage.screen;
    scaled_next.wave_a     = stage.wave_a;
    scaled_next.wave_b     = stage.wave_b;
    scaled_next.offset     = stage.offset;
    scaled_next.trig       = 6'd1 + trig_prod[17:12];
    scaled_next.volt       = 3'd1 + {1'b0, stage.mean[KNOB_VOLT][11:10]};
    scaled_next.tdiv       = time_prod[14:12];
    scaled_next.freq_raw_a = 15'(FREQ_BASE) + freq_a_prod[26:12];
    scaled_next.freq_raw_b = 15'(FREQ_BASE) + freq_b_prod[26:12];
    scaled_next.amp_a      = stage.mean[KNOB_VOLT];
    scaled_next.amp_b      = stage.mean[KNOB_TRIG];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled_valid <= 1'b0;
    end else if (scaled_free) begin
      scaled_valid <= stage_valid;
    end
    if (stage_valid && scaled_free) begin
      scaled <= scaled_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sfpc_settle.sv
// ----------------------------------------------------------------------------
// Front panel settings stage
// Rounds the generator frequencies down to whole steps, updates the held
// scope or generator settings for the current mode and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpc_settle import sfpc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire scaled_t scaled,
  input  wire logic    scaled_valid,
  output logic         scaled_free,
  output panel_t       panel,
  output logic         panel_valid,
  input  wire logic    panel_stall
);

  localparam logic [16:0] FREQ_RECIP_L = 17'(FREQ_RECIP);

  logic              out_free;
  logic              take;
  logic [31:0]       quot_a_prod;
  logic [31:0]       quot_b_prod;
  logic [9:0]        quot_a;
  logic [9:0]        quot_b;
  logic [14:0]       freq_a_round;
  logic [14:0]       freq_b_round;
  logic [5:0]        trig_reg;
  logic [5:0]        trig_next;
  logic [2:0]        volt_reg;
  logic [2:0]        volt_next;
  logic [2:0]        tdiv_reg;
  logic [2:0]        tdiv_next;
  logic [14:0]       freq_a_reg;
  logic [14:0]       freq_a_next;
  logic [14:0]       freq_b_reg;
  logic [14:0]       freq_b_next;
  logic [KNOB_W-1:0] amp_a_reg;
  logic [KNOB_W-1:0] amp_a_next;
  logic [KNOB_W-1:0] amp_b_reg;
  logic [KNOB_W-1:0] amp_b_next;
  panel_t            panel_next;

  assign out_free    = !panel_valid || !panel_stall;
  assign scaled_free = !scaled_valid || out_free;
  assign take        = scaled_valid && out_free;

  assign quot_a_prod  = 32'(scaled.freq_raw_a) * 32'(FREQ_RECIP_L);
  assign quot_b_prod  = 32'(scaled.freq_raw_b) * 32'(FREQ_RECIP_L);
  assign quot_a       = quot_a_prod[FREQ_RECIP_SHIFT +: 10];
  assign quot_b       = quot_b_prod[FREQ_RECIP_SHIFT +: 10];
  assign freq_a_round = {quot_a, 5'b0} + {1'b0, quot_a, 4'b0} + {4'b0, quot_a, 1'b0};
  assign freq_b_round = {quot_b, 5'b0} + {1'b0, quot_b, 4'b0} + {4'b0, quot_b, 1'b0};

  always_comb begin
    trig_next   = trig_reg;
    volt_next   = volt_reg;
    tdiv_next   = tdiv_reg;
    freq_a_next = freq_a_reg;
    freq_b_next = freq_b_reg;
    amp_a_next  = amp_a_reg;
    amp_b_next  = amp_b_reg;
    if (scaled.screen == SCR_SCOPE) begin
      trig_next = scaled.trig;
      volt_next = scaled.volt;
      tdiv_next = scaled.tdiv;
    end else if (scaled.screen == SCR_GEN) begin
      freq_a_next = freq_a_round;
      freq_b_next = freq_b_round;
      amp_a_next  = scaled.amp_a;
      amp_b_next  = scaled.amp_b;
    end
  end

  always_comb begin
    panel_next.screen         = scaled.screen;
    panel_next.wave_a         = scaled.wave_a;
    panel_next.wave_b         = scaled.wave_b;
    panel_next.trace_offset   = scaled.offset;
    panel_next.trigger_level  = trig_next;
    panel_next.volt_div       = volt_next;
    panel_next.time_div_index = tdiv_next;
    panel_next.sample_skip    = skip_for_index(tdiv_next);
    panel_next.freq_a         = freq_a_next;
    panel_next.freq_b         = freq_b_next;
    panel_next.amp_a          = amp_a_next;
    panel_next.amp_b          = amp_b_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_reg   <= 6'd1;
      volt_reg   <= 3'd1;
      tdiv_reg   <= 3'd0;
      freq_a_reg <= 15'(FREQ_BASE);
      freq_b_reg <= 15'(FREQ_BASE);
      amp_a_reg  <= '0;
      amp_b_reg  <= '0;
    end else if (take) begin
      trig_reg   <= trig_next;
      volt_reg   <= volt_next;
      tdiv_reg   <= tdiv_next;
      freq_a_reg <= freq_a_next;
      freq_b_reg <= freq_b_next;
      amp_a_reg  <= amp_a_next;
      amp_b_reg  <= amp_b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_valid <= 1'b0;
    end else if (out_free) begin
      panel_valid <= scaled_valid;
    end
    if (take) begin
      panel <= panel_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/scope_front_panel_controller_unit.sv
// ----------------------------------------------------------------------------
// Scope front panel controller
// Top level: turns knob and button sampling rounds into panel settings.
// ----------------------------------------------------------------------------
// One sampling round is accepted every clock cycle while round_stall is low,
// and every SAMPLES-th round produces one panel transaction: the round is
// taken into the input register, then passes the mean register, the scaling
// register and the output register. Each of these stages multiplies only by
// constants, and every stage advances as soon as the next one is empty or
// moving, so the sustained rate is one round per cycle while the panel side
// keeps taking transactions. Buttons are sampled only on the last round of
// each block, and the settings of the mode that is not shown hold their
// last values.
`default_nettype none

module scope_front_panel_controller_unit import sfpc_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire round_t round,
  input  wire logic   round_valid,
  output logic        round_stall,
  output panel_t      panel,
  output logic        panel_valid,
  input  wire logic   panel_stall
);

  mean_t   stage;
  logic    stage_valid;
  logic    stage_free;
  scaled_t scaled;
  logic    scaled_valid;
  logic    scaled_free;

  sfpc_front #(
    .SAMPLES(SAMPLES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .round      (round),
    .round_valid(round_valid),
    .round_stall(round_stall),
    .stage      (stage),
    .stage_valid(stage_valid),
    .stage_free (stage_free)
  );

  sfpc_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .stage       (stage),
    .stage_valid (stage_valid),
    .stage_free  (stage_free),
    .scaled      (scaled),
    .scaled_valid(scaled_valid),
    .scaled_free (scaled_free)
  );

  sfpc_settle u_settle (
    .clk         (clk),
    .rst         (rst),
    .scaled      (scaled),
    .scaled_valid(scaled_valid),
    .scaled_free (scaled_free),
    .panel       (panel),
    .panel_valid (panel_valid),
    .panel_stall (panel_stall)
  );

`ifndef SYNTHESIS
  a_stall_needs_full_stage: assert property (@(posedge clk) disable iff (rst)
    round_stall |-> stage_valid)
    else $error("Input stalled while the mean stage was empty.");

  a_result_from_pipeline: assert property (@(posedge clk) disable iff (rst)
    $rose(panel_valid) |-> $past(scaled_valid))
    else $error("Panel transaction appeared without a scaled item behind it.");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    panel_valid |-> panel.trace_offset >= OFFSET_MIN && panel.trace_offset <= OFFSET_MAX)
    else $error("Trace offset left its saturation range.");
`endif

endmodule

`default_nettype wire

// File: dv/tb_scope_front_panel_controller_unit.sv
// ----------------------------------------------------------------------------
// Scope front panel controller testbench
// Sends sampling rounds of knob samples and button levels, predicts every
// panel transaction with an independent model of the menu, offset, wave and
// scaling logic, and compares each field of each panel transaction in order.
// ----------------------------------------------------------------------------
module tb_scope_front_panel_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sfpc_pkg::*;

  localparam int BLOCK_ROUNDS    = SAMPLES_DEF;
  localparam int TOTAL_ROUNDS    = 1450;
  localparam int KNOB_SCALE      = 4096;
  localparam int IDLE_LIMIT      = 3000;
  localparam int DRAIN_CYCLES    = 20;
  localparam logic [3:0] ALL_UP  = 4'hF;

  typedef enum int {
    KNOBS_RANDOM,
    KNOBS_ZERO,
    KNOBS_FULL
  } knob_style_t;

  logic   clk = 1'b0;
  logic   rst;
  round_t round;
  logic   round_valid;
  logic   round_stall;
  panel_t panel;
  logic   panel_valid;
  logic   panel_stall = 1'b0;

  logic   round_fire;
  logic   panel_fire;
  panel_t panel_seen;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned rounds_sent;
  int unsigned panels_checked;
  int unsigned failures;

  logic [SUM_W-1:0]  knob_acc [NUM_KNOBS];
  int unsigned       block_pos;
  logic [3:0]        last_levels;
  screen_t           cur_screen;
  logic [1:0]        wave_ch [2];
  logic [4:0]        offset_now;
  logic [5:0]        trig_hold;
  logic [2:0]        volt_hold;
  logic [2:0]        tdiv_hold;
  logic [14:0]       freq_hold [2];
  logic [KNOB_W-1:0] amp_hold [2];
  logic [5:0]        screens_seen;
  int unsigned       offset_clamps;
  panel_t            expected_panels [$];

  always #1 clk = ~clk;

  scope_front_panel_controller_unit #(
    .SAMPLES(BLOCK_ROUNDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .round(round),
    .round_valid(round_valid),
    .round_stall(round_stall),
    .panel(panel),
    .panel_valid(panel_valid),
    .panel_stall(panel_stall)
  );

  always @(negedge clk) begin
    round_fire = round_valid && !round_stall;
    panel_fire = panel_valid && !panel_stall;
    panel_seen = panel;
  end

  function automatic logic [1:0] step_wave(input logic [1:0] w);
    logic [1:0] n;
    case (w)
      WAVE_FIRST:  n = WAVE_SECOND;
      WAVE_SECOND: n = WAVE_THIRD;
      default:     n = WAVE_FIRST;
    endcase
    return n;
  endfunction

  function automatic logic [14:0] freq_from_mean(input int unsigned m);
    int unsigned f;
    f = FREQ_BASE + m * FREQ_SPAN / KNOB_SCALE;
    return 15'(f / FREQ_STEP * FREQ_STEP);
  endfunction

  function automatic void reset_panel_model();
    for (int i = 0; i < NUM_KNOBS; i++) knob_acc[i] = '0;
    block_pos = 0;
    last_levels = ALL_UP;
    cur_screen = SCR_MENU0;
    wave_ch[0] = WAVE_FIRST;
    wave_ch[1] = WAVE_FIRST;
    offset_now = OFFSET_MIN;
    trig_hold = 6'd1;
    volt_hold = 3'd1;
    tdiv_hold = 3'd0;
    freq_hold[0] = 15'(FREQ_BASE);
    freq_hold[1] = 15'(FREQ_BASE);
    amp_hold[0] = '0;
    amp_hold[1] = '0;
    screens_seen = 6'b000001;
    offset_clamps = 0;
  endfunction

  // Accumulates one round and, on the last round of a block, queues the
  // panel transaction that the block is expected to produce.
  function automatic void predict_panel(input round_t r);
    logic [KNOB_W-1:0] knob_in [NUM_KNOBS];
    int unsigned       mean [NUM_KNOBS];
    logic [3:0]        levels;
    logic [3:0]        falls;
    panel_t            p;
    knob_in[KNOB_TIME]   = r.knob_time;
    knob_in[KNOB_VOLT]   = r.knob_volt;
    knob_in[KNOB_TRIG]   = r.knob_trig;
    knob_in[KNOB_FREQ_A] = r.knob_freq_a;
    knob_in[KNOB_FREQ_B] = r.knob_freq_b;
    for (int i = 0; i < NUM_KNOBS; i++) knob_acc[i] = knob_acc[i] + SUM_W'(knob_in[i]);
    block_pos++;
    if (block_pos < BLOCK_ROUNDS) return;
    for (int i = 0; i < NUM_KNOBS; i++) begin
      mean[i] = knob_acc[i] / BLOCK_ROUNDS;
      knob_acc[i] = '0;
    end
    block_pos = 0;

    levels[BTN_SCROLL] = r.scroll_level;
    levels[BTN_SELECT] = r.select_level;
    levels[BTN_LEFT]   = r.left_level;
    levels[BTN_RIGHT]  = r.right_level;
    falls = last_levels & ~levels;
    last_levels = levels;

    if (falls[BTN_SCROLL] && cur_screen < SCR_SCOPE)
      cur_screen = screen_t'((int'(cur_screen) + 1) % 3);
    if (falls[BTN_SELECT]) begin
      if (cur_screen < SCR_SCOPE) cur_screen = screen_t'(int'(cur_screen) + 3);
      else cur_screen = screen_t'((int'(cur_screen) - 3) % 3);
    end
    if (falls[BTN_LEFT]) begin
      if (cur_screen == SCR_GEN) begin
        wave_ch[0] = step_wave(wave_ch[0]);
      end else if (cur_screen == SCR_SCOPE) begin
        if (offset_now < OFFSET_MAX) offset_now++;
        else offset_clamps++;
      end
    end
    if (falls[BTN_RIGHT]) begin
      if (cur_screen == SCR_GEN) begin
        wave_ch[1] = step_wave(wave_ch[1]);
      end else if (cur_screen == SCR_SCOPE) begin
        if (offset_now > OFFSET_MIN) offset_now--;
        else offset_clamps++;
      end
    end
    screens_seen[cur_screen] = 1'b1;

    if (cur_screen == SCR_SCOPE) begin
      trig_hold = 6'(1 + mean[KNOB_TRIG] * TRIG_SPAN / KNOB_SCALE);
      volt_hold = 3'(1 + mean[KNOB_VOLT] * 4 / KNOB_SCALE);
      tdiv_hold = 3'(mean[KNOB_TIME] * TIME_STEPS / KNOB_SCALE);
    end else if (cur_screen == SCR_GEN) begin
      freq_hold[0] = freq_from_mean(mean[KNOB_FREQ_A]);
      freq_hold[1] = freq_from_mean(mean[KNOB_FREQ_B]);
      amp_hold[0] = KNOB_W'(mean[KNOB_VOLT]);
      amp_hold[1] = KNOB_W'(mean[KNOB_TRIG]);
    end

    p.screen         = cur_screen;
    p.wave_a         = wave_ch[0];
    p.wave_b         = wave_ch[1];
    p.trace_offset   = offset_now;
    p.trigger_level  = trig_hold;
    p.volt_div       = volt_hold;
    p.time_div_index = tdiv_hold;
    case (tdiv_hold)
      3'd0:    p.sample_skip = 7'd1;
      3'd1:    p.sample_skip = 7'd5;
      3'd2:    p.sample_skip = 7'd10;
      3'd3:    p.sample_skip = 7'd19;
      3'd4:    p.sample_skip = 7'd48;
      default: p.sample_skip = 7'd96;
    endcase
    p.freq_a = freq_hold[0];
    p.freq_b = freq_hold[1];
    p.amp_a  = amp_hold[0];
    p.amp_b  = amp_hold[1];
    expected_panels.push_back(p);
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("panel field %s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  task automatic check_panel(input panel_t got);
    panel_t want;
    if (expected_panels.size() == 0) begin
      $error("panel transaction with no expectation pending: %h", got);
      failures++;
      return;
    end
    want = expected_panels.pop_front();
    panels_checked++;
    check_field("screen", want.screen, got.screen);
    check_field("wave_a", want.wave_a, got.wave_a);
    check_field("wave_b", want.wave_b, got.wave_b);
    check_field("trace_offset", want.trace_offset, got.trace_offset);
    check_field("trigger_level", want.trigger_level, got.trigger_level);
    check_field("volt_div", want.volt_div, got.volt_div);
    check_field("time_div_index", want.time_div_index, got.time_div_index);
    check_field("sample_skip", want.sample_skip, got.sample_skip);
    check_field("freq_a", want.freq_a, got.freq_a);
    check_field("freq_b", want.freq_b, got.freq_b);
    check_field("amp_a", want.amp_a, got.amp_a);
    check_field("amp_b", want.amp_b, got.amp_b);
  endtask

  always @(posedge clk) begin
    panel_stall <= ($urandom_range(99) < recv_idle_pct);
    if (!rst && panel_fire === 1'b1) check_panel(panel_seen);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (round_fire === 1'b1 || panel_fire === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic update_idle_mix();
    if (rounds_sent < TOTAL_ROUNDS / 3) begin
      send_idle_pct = 31;
      recv_idle_pct = 62;
    end else if (rounds_sent < 2 * TOTAL_ROUNDS / 3) begin
      send_idle_pct = 62;
      recv_idle_pct = 31;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic send_round(input round_t r);
    logic taken;
    update_idle_mix();
    while ($urandom_range(99) < send_idle_pct) begin
      round_valid <= 1'b0;
      @(posedge clk);
    end
    round <= r;
    round_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !round_stall;
      @(posedge clk);
    end while (!taken);
    predict_panel(r);
    rounds_sent++;
  endtask

  function automatic logic [KNOB_W-1:0] knob_sample(input knob_style_t style);
    logic [KNOB_W-1:0] k;
    case (style)
      KNOBS_ZERO: k = '0;
      KNOBS_FULL: k = '1;
      default:    k = KNOB_W'($urandom_range(4095));
    endcase
    return k;
  endfunction

  function automatic knob_style_t pick_style();
    int unsigned d;
    d = $urandom_range(9);
    if (d == 0) return KNOBS_ZERO;
    if (d == 1) return KNOBS_FULL;
    return KNOBS_RANDOM;
  endfunction

  function automatic logic [3:0] btn_mask(input int idx);
    return 4'(1 << idx);
  endfunction

  // Levels on rounds other than the last of a block must be ignored, so they
  // are random there.
  task automatic send_block(input logic [3:0] levels, input knob_style_t style);
    round_t r;
    logic [3:0] lv;
    for (int i = 0; i < BLOCK_ROUNDS; i++) begin
      lv = (i == BLOCK_ROUNDS - 1) ? levels : 4'($urandom);
      r.scroll_level = lv[BTN_SCROLL];
      r.select_level = lv[BTN_SELECT];
      r.left_level   = lv[BTN_LEFT];
      r.right_level  = lv[BTN_RIGHT];
      r.knob_time    = knob_sample(style);
      r.knob_volt    = knob_sample(style);
      r.knob_trig    = knob_sample(style);
      r.knob_freq_a  = knob_sample(style);
      r.knob_freq_b  = knob_sample(style);
      send_round(r);
    end
  endtask

  task automatic tap(input logic [3:0] pressed);
    send_block(ALL_UP, pick_style());
    send_block(~pressed, pick_style());
  endtask

  task automatic goto_screen(input screen_t target);
    while (cur_screen != target) begin
      if (cur_screen >= SCR_SCOPE)
        tap(btn_mask(BTN_SELECT));
      else if (target >= SCR_SCOPE && int'(cur_screen) == int'(target) - 3)
        tap(btn_mask(BTN_SELECT));
      else
        tap(btn_mask(BTN_SCROLL));
    end
  endtask

  task automatic wait_drained();
    round_valid <= 1'b0;
    @(posedge clk);
    while (expected_panels.size() != 0) @(posedge clk);
  endtask

  // Full-scale and zero knobs in scope mode give the limits of every
  // scope setting.
  task automatic test_extreme_knobs();
    send_block(~btn_mask(BTN_SELECT), KNOBS_FULL);
    send_block(ALL_UP, KNOBS_ZERO);
  endtask

  task automatic test_offset_limits();
    logic [3:0] m;
    goto_screen(SCR_SCOPE);
    repeat (2) tap(btn_mask(BTN_RIGHT));
    repeat (31) begin
      m = btn_mask(BTN_LEFT);
      m[BTN_SCROLL] = $urandom_range(1);
      tap(m);
    end
    repeat (2) tap(btn_mask(BTN_LEFT) | btn_mask(BTN_RIGHT));
  endtask

  task automatic test_generator_waves();
    goto_screen(SCR_GEN);
    repeat (8) begin
      tap(4'($urandom_range(1, 3)) << BTN_LEFT);
    end
    tap(btn_mask(BTN_SELECT));
    tap(btn_mask(BTN_LEFT) | btn_mask(BTN_RIGHT));
    tap(btn_mask(BTN_SELECT));
  endtask

  task automatic test_menu_and_about();
    goto_screen(SCR_ABOUT);
    tap(btn_mask(BTN_LEFT));
    tap(btn_mask(BTN_RIGHT) | btn_mask(BTN_SCROLL));
    goto_screen(SCR_MENU0);
    tap(btn_mask(BTN_LEFT) | btn_mask(BTN_RIGHT));
    tap(btn_mask(BTN_SCROLL) | btn_mask(BTN_SELECT));
  endtask

  task automatic test_random_panel();
    logic [3:0] m;
    while (rounds_sent < TOTAL_ROUNDS) begin
      if ($urandom_range(3) == 0) begin
        send_block(4'($urandom), pick_style());
      end else begin
        for (int b = 0; b < NUM_BTNS; b++) m[b] = ($urandom_range(99) < 40);
        tap(m);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    round = '0;
    round_valid = 1'b0;
    rounds_sent = 0;
    panels_checked = 0;
    failures = 0;
    update_idle_mix();
    reset_panel_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extreme_knobs();
    test_offset_limits();
    wait_drained();
    test_generator_waves();
    test_menu_and_about();
    wait_drained();
    test_random_panel();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d sampling rounds and checked %0d panel transactions.",
             rounds_sent, panels_checked);
    $display("Screens reached %b, offset presses held at a limit %0d times.",
             screens_seen, offset_clamps);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
